/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/rfamp_pkg.sv */
package rfamp_pkg;

    localparam int PIN_W = 17;

    // pin bit positions
    localparam int P_ON5V            = 0;
    localparam int P_ON50V           = 1;
    localparam int P_IN_AMP2_920     = 2;
    localparam int P_IN_AMP3_920     = 3;
    localparam int P_SEL_LNAOUT2_920 = 4;
    localparam int P_SEL_LNAOUT3_920 = 5;
    localparam int P_SELLNA_LNA_920  = 6;
    localparam int P_ON_LNA1_920     = 7;
    localparam int P_SELLNA_EXT_920  = 8;
    localparam int P_SELPWR_LNA_920  = 9;
    localparam int P_SELPWR_AMP_920  = 10;
    localparam int P_ON_LNA2_920     = 11;
    localparam int P_LNA_IN1_24      = 12;
    localparam int P_LNA_IN2_24      = 13;
    localparam int P_LNA_ON_24       = 14;
    localparam int P_SEL_PWR_LNA_24  = 15;
    localparam int P_ON_AMP_24       = 16;

    // pins dropped on entry to fault
    localparam logic [PIN_W-1:0] SHUTDOWN_MASK =
        PIN_W'((1 << P_ON5V) | (1 << P_ON50V) | (1 << P_ON_AMP_24) | (1 << P_SELPWR_AMP_920));

    localparam logic [7:0] CMD_MONITOR  = 8'h01;
    localparam logic [7:0] CMD_RAIL_5V  = 8'h04;
    localparam logic [7:0] CMD_RAIL_50V = 8'h05;
    localparam logic [7:0] CMD_STANDBY  = 8'h10;
    localparam logic [7:0] CMD_OFF      = 8'h11;
    localparam logic [7:0] CMD_TX       = 8'h12;

    localparam logic [7:0] SEL_GLOBAL  = 8'hFF;
    localparam logic [7:0] SEL_AMP_920 = 8'h01;
    localparam logic [7:0] SEL_AMP_24  = 8'h02;

    localparam logic [5:0] MIN_CMD_BYTES = 6'd4;
    localparam logic [2:0] MONITOR_LEN   = 3'd4;

    localparam logic       REQ_SAMPLE  = 1'b0;

    localparam int         CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_LIMIT  = 2'd1;

    localparam logic signed [16:0] TEMP_LIMIT_RST = 17'sd9000;
    localparam logic        [12:0] CUR_LIMIT_RST  = 13'd4500;

    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_TX      = 2'd1,
        MODE_OFF     = 2'd2
    } mode_t;

    typedef struct packed {
        logic        req_type;
        logic [11:0] temp_raw;
        logic [11:0] current_raw;
        logic [5:0]  byte_count;
        logic [7:0]  command;
        logic [7:0]  amp_select;
        logic [7:0]  argument;
    } in_item_t;

    typedef struct packed {
        logic             fault;
        logic             resp_status;
        logic [2:0]       resp_data_len;
        logic [15:0]      resp_temp;
        logic [12:0]      resp_current;
        logic [PIN_W-1:0] pin_levels;
        mode_t            mode_920;
        mode_t            mode_24;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [16:0]          wdata;
    } cfg_req_t;

    // converted sample handed from conversion to control
    typedef struct packed {
        logic signed [16:0] temp_centi;
        logic        [12:0] current_ma;
        logic               over_limit;
    } conv_t;

endpackage

/* rtl/rfamp_chan_if.sv */
interface rfamp_chan_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rfamp_conv.sv */
module rfamp_conv (
    input  logic [11:0]         temp_raw,
    input  logic [11:0]         current_raw,
    input  logic signed [16:0]  temp_limit,
    input  logic [12:0]         cur_limit,
    output rfamp_pkg::conv_t    conv
);
    import rfamp_pkg::*;

    // temp = 35756 - 18*raw - ceil((52188*raw - 22113) / 70434)
    // the ceil term is floor((52188*raw + 48320) / 70434), done by reciprocal
    localparam logic [63:0] T_RECIP = ((64'd1 << 45) + 64'd70433) / 64'd70434;
    localparam logic [63:0] T_C1    = 64'd52188 * T_RECIP;
    localparam logic [63:0] T_C0    = 64'd48320 * T_RECIP;
    // current = floor(raw*5000 / 4095)
    localparam logic [63:0] C_RECIP = ((64'd1 << 37) + 64'd4094) / 64'd4095;
    localparam logic [63:0] C_C1    = 64'd5000 * C_RECIP;

    logic [63:0]        t_prod;
    logic [11:0]        t_corr;
    logic [16:0]        t_lin;
    logic signed [17:0] t_wide;
    logic [63:0]        c_prod;

    always_comb
    begin
        t_prod = {52'd0, temp_raw} * T_C1 + T_C0;
        t_corr = t_prod[56:45];
        t_lin  = {5'd0, temp_raw} * 17'd18;
        t_wide = 18'sd35756 - $signed({1'b0, t_lin}) - $signed({6'd0, t_corr});
        c_prod = {52'd0, current_raw} * C_C1;

        conv.temp_centi = t_wide[16:0];
        conv.current_ma = c_prod[49:37];
        conv.over_limit = ($signed(t_wide[16:0]) > temp_limit) ||
                          (c_prod[49:37] > cur_limit);
    end
endmodule

/* rtl/rfamp_core.sv */
`include "assert_macros.svh"

module rfamp_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  rfamp_pkg::in_item_t  item,
    input  rfamp_pkg::conv_t     conv,
    output rfamp_pkg::out_item_t result_next
);
    import rfamp_pkg::*;

    // reset view: everything low, both chains off
    localparam out_item_t STATE_RST = '{
        fault:         1'b0,
        resp_status:   1'b0,
        resp_data_len: 3'd0,
        resp_temp:     16'd0,
        resp_current:  13'd0,
        pin_levels:    '0,
        mode_920:      MODE_OFF,
        mode_24:       MODE_OFF
    };

    out_item_t          state_reg;
    out_item_t          state_next;
    logic signed [16:0] temp_reg;
    logic signed [16:0] temp_next;
    logic [12:0]        cur_reg;
    logic [12:0]        cur_next;

    function automatic logic [PIN_W-1:0] standby_920(input logic [PIN_W-1:0] p_in);
        logic [PIN_W-1:0] p;
        p = p_in;
        p[P_SELPWR_LNA_920]  = 1'b1;
        p[P_SELPWR_AMP_920]  = 1'b0;
        p[P_SELLNA_LNA_920]  = 1'b1;
        p[P_SELLNA_EXT_920]  = 1'b0;
        p[P_IN_AMP2_920]     = 1'b1;
        p[P_IN_AMP3_920]     = 1'b1;
        p[P_SEL_LNAOUT2_920] = 1'b1;
        p[P_SEL_LNAOUT3_920] = 1'b0;
        p[P_ON_LNA1_920]     = 1'b1;
        p[P_ON_LNA2_920]     = 1'b1;
        p[P_ON5V]            = 1'b1;
        return p;
    endfunction

    function automatic logic [PIN_W-1:0] standby_24(input logic [PIN_W-1:0] p_in);
        logic [PIN_W-1:0] p;
        p = p_in;
        p[P_SEL_PWR_LNA_24] = 1'b1;
        p[P_LNA_ON_24]      = 1'b1;
        p[P_LNA_IN1_24]     = 1'b1;
        p[P_LNA_IN2_24]     = 1'b0;
        p[P_ON_AMP_24]      = 1'b0;
        p[P_ON5V]           = 1'b1;
        return p;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        temp_next  = temp_reg;
        cur_next   = cur_reg;

        if (item.req_type == REQ_SAMPLE)
        begin
            temp_next = conv.temp_centi;
            cur_next  = conv.current_ma;
            if (conv.over_limit)
            begin
                // shutdown only on the way into fault
                if (!state_reg.fault)
                begin
                    state_next.fault      = 1'b1;
                    state_next.pin_levels = state_reg.pin_levels & ~SHUTDOWN_MASK;
                    state_next.mode_920   = MODE_OFF;
                    state_next.mode_24    = MODE_OFF;
                end
            end
            else
            begin
                state_next.fault = 1'b0;
            end
        end
        else if (item.byte_count >= MIN_CMD_BYTES)
        begin
            state_next.resp_status   = state_reg.fault;
            state_next.resp_data_len = '0;
            state_next.resp_temp     = '0;
            state_next.resp_current  = '0;
            case (item.amp_select)
                SEL_GLOBAL:
                begin
                    case (item.command)
                        CMD_MONITOR:
                        begin
                            state_next.resp_data_len = MONITOR_LEN;
                            state_next.resp_temp     = temp_reg[16] ? 16'd0 : temp_reg[15:0];
                            state_next.resp_current  = cur_reg;
                        end
                        CMD_RAIL_5V:  state_next.pin_levels[P_ON5V]  = (item.argument != 8'd0);
                        CMD_RAIL_50V: state_next.pin_levels[P_ON50V] = (item.argument != 8'd0);
                        default: ;
                    endcase
                end
                SEL_AMP_920:
                begin
                    if (!state_reg.fault)
                    begin
                        // any other code leaves a non-standby mode via standby first
                        if (state_reg.mode_920 != MODE_STANDBY &&
                            item.command != CMD_STANDBY && item.command != CMD_OFF)
                        begin
                            state_next.pin_levels = standby_920(state_next.pin_levels);
                            state_next.mode_920   = MODE_STANDBY;
                        end
                        case (item.command)
                            CMD_STANDBY:
                            begin
                                state_next.pin_levels = standby_920(state_next.pin_levels);
                                state_next.mode_920   = MODE_STANDBY;
                            end
                            CMD_OFF:
                            begin
                                state_next.pin_levels[P_ON5V] = 1'b0;
                                state_next.mode_920           = MODE_OFF;
                            end
                            CMD_TX:
                            begin
                                state_next.pin_levels[P_SELPWR_LNA_920] = 1'b0;
                                state_next.pin_levels[P_SELPWR_AMP_920] = 1'b1;
                                state_next.pin_levels[P_IN_AMP2_920]    = item.argument[0];
                                state_next.pin_levels[P_IN_AMP3_920]    = item.argument[1];
                                state_next.mode_920                     = MODE_TX;
                            end
                            default: ;
                        endcase
                    end
                end
                SEL_AMP_24:
                begin
                    if (!state_reg.fault)
                    begin
                        if (state_reg.mode_24 != MODE_STANDBY &&
                            item.command != CMD_STANDBY && item.command != CMD_OFF)
                        begin
                            state_next.pin_levels = standby_24(state_next.pin_levels);
                            state_next.mode_24    = MODE_STANDBY;
                        end
                        case (item.command)
                            CMD_STANDBY:
                            begin
                                state_next.pin_levels = standby_24(state_next.pin_levels);
                                state_next.mode_24    = MODE_STANDBY;
                            end
                            CMD_OFF:
                            begin
                                state_next.pin_levels[P_ON5V] = 1'b0;
                                state_next.mode_24            = MODE_OFF;
                            end
                            CMD_TX:
                            begin
                                state_next.pin_levels[P_SEL_PWR_LNA_24] = 1'b0;
                                state_next.pin_levels[P_LNA_IN1_24]     = item.argument[0];
                                state_next.pin_levels[P_LNA_IN2_24]     = item.argument[1];
                                state_next.pin_levels[P_ON_AMP_24]      = 1'b1;
                                state_next.mode_24                      = MODE_TX;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign result_next = state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RST;
            temp_reg  <= '0;
            cur_reg   <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            temp_reg  <= temp_next;
            cur_reg   <= cur_next;
        end
    end

    `ASSERT_IMPL(a_fault_modes_off, clk, rst_n, state_reg.fault,
        state_reg.mode_920 == MODE_OFF && state_reg.mode_24 == MODE_OFF,
        "amplifier left off mode while in fault")
    `ASSERT_IMPL(a_fault_entry_pins, clk, rst_n, $rose(state_reg.fault),
        (state_reg.pin_levels & SHUTDOWN_MASK) == '0,
        "power pins still up on fault entry")
    `ASSERT_IMPL(a_tx920_power, clk, rst_n, state_reg.mode_920 == MODE_TX,
        state_reg.pin_levels[P_SELPWR_AMP_920],
        "920 transmit without amplifier supply selected")
endmodule

/* rtl/rf_amp_mode_and_fault_controller_top.sv */
// Channel  Dir  Payload                                   Handshake
// in       in   in_item_t: sample or bus command request  valid/ready
// out      out  out_item_t: flags, response, pins, modes  valid/ready
// cfg      in   cfg_req_t: reg_index, wdata               valid/ready (ready tied high)
//
// Result path: the input register, then one pass of conversion and control logic
// into the result register, which loads once the result side is free.
// One request per cycle sustained while out is being taken; the state update is
// a loop from the core state registers through the control logic and back.
// Async active-low reset: no pending requests, modes off, pins low, limits 9000 / 4500.
// A stalled out holds its result; one more request still lands in the input register.
`include "assert_macros.svh"

module rf_amp_mode_and_fault_controller_top (
    input  logic         clk,
    input  logic         rst_n,
    rfamp_chan_if.sink   in,
    rfamp_chan_if.source out,
    rfamp_chan_if.sink   cfg
);
    import rfamp_pkg::*;

    // configuration
    logic signed [16:0] temp_limit_reg;
    logic [12:0]        cur_limit_reg;

    // input register
    logic      in_valid_reg;
    in_item_t  in_data_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      out_free;
    logic      fire;
    logic      in_take;
    conv_t     conv;
    out_item_t result_next;

    assign out_free  = !out_valid_reg || out.ready;
    assign fire      = in_valid_reg && out_free;
    assign in.ready  = !in_valid_reg || out_free;
    assign in_take   = in.valid && in.ready;
    assign cfg.ready = 1'b1;

    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_limit_reg <= TEMP_LIMIT_RST;
            cur_limit_reg  <= CUR_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.reg_index)
                CFG_TEMP_LIMIT: temp_limit_reg <= cfg.data.wdata;
                CFG_CUR_LIMIT:  cur_limit_reg  <= cfg.data.wdata[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in.data;
        end
        if (fire)
        begin
            out_data_reg <= result_next;
        end
    end

    rfamp_conv u_conv (
        .temp_raw    (in_data_reg.temp_raw),
        .current_raw (in_data_reg.current_raw),
        .temp_limit  (temp_limit_reg),
        .cur_limit   (cur_limit_reg),
        .conv        (conv)
    );

    rfamp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (in_data_reg),
        .conv        (conv),
        .result_next (result_next)
    );

    `ASSERT_PROP(a_held_request_kept, clk, rst_n,
        (in_valid_reg && !out_free) |=> in_valid_reg,
        "pending request dropped while result stalled")
    `ASSERT_PROP(a_fire_gives_result, clk, rst_n,
        fire |=> out_valid_reg,
        "processed request produced no result")
    `ASSERT_PROP(a_stalled_result_held, clk, rst_n,
        (out_valid_reg && !out.ready) |=> (out_valid_reg && $stable(out_data_reg)),
        "stalled result changed before it was taken")
endmodule

/* tb/rfamp_checker.sv */
`timescale 1ns / 100ps

// Watches the request, result and register channels, keeps its own copy of the
// controller state and compares every result with the oldest prediction.
module rfamp_state_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  rfamp_pkg::in_item_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  rfamp_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  rfamp_pkg::cfg_req_t  cfg_data,
    output int                   failures,
    output int                   results_checked
);
    import rfamp_pkg::*;

    logic signed [16:0] temp_lim;
    logic        [12:0] cur_lim;

    logic               fault_q;
    logic signed [16:0] temp_c;
    logic        [12:0] cur_ma;
    logic   [PIN_W-1:0] pins;
    mode_t              m920;
    mode_t              m24;
    logic               lat_status;
    logic         [2:0] lat_len;
    logic        [15:0] lat_temp;
    logic        [12:0] lat_cur;

    out_item_t status_due[$];
    int        n_bad = 0;

    assign failures = n_bad;

    function automatic void park_920();
        pins[P_SELPWR_LNA_920]  = 1'b1;
        pins[P_SELPWR_AMP_920]  = 1'b0;
        pins[P_SELLNA_LNA_920]  = 1'b1;
        pins[P_SELLNA_EXT_920]  = 1'b0;
        pins[P_IN_AMP2_920]     = 1'b1;
        pins[P_IN_AMP3_920]     = 1'b1;
        pins[P_SEL_LNAOUT2_920] = 1'b1;
        pins[P_SEL_LNAOUT3_920] = 1'b0;
        pins[P_ON_LNA1_920]     = 1'b1;
        pins[P_ON_LNA2_920]     = 1'b1;
        pins[P_ON5V]            = 1'b1;
        m920 = MODE_STANDBY;
    endfunction

    function automatic void park_24();
        pins[P_SEL_PWR_LNA_24] = 1'b1;
        pins[P_LNA_ON_24]      = 1'b1;
        pins[P_LNA_IN1_24]     = 1'b1;
        pins[P_LNA_IN2_24]     = 1'b0;
        pins[P_ON_AMP_24]      = 1'b0;
        pins[P_ON5V]           = 1'b1;
        m24 = MODE_STANDBY;
    endfunction

    function automatic void take_sample(logic [11:0] t_raw, logic [11:0] c_raw);
        longint span;
        longint q;
        // exact centi-degree value, rounded half up
        span   = 64'sd3020062500 - 64'sd660000 * longint'(t_raw);
        q      = (2 * span + 35217) / 70434;
        temp_c = 17'(q - 50000);
        cur_ma = 13'((int'(c_raw) * 5000) / 4095);
        if (temp_c > temp_lim || cur_ma > cur_lim)
        begin
            if (!fault_q)
            begin
                fault_q = 1'b1;
                pins[P_ON5V]           = 1'b0;
                pins[P_ON50V]          = 1'b0;
                pins[P_ON_AMP_24]      = 1'b0;
                pins[P_SELPWR_AMP_920] = 1'b0;
                m920 = MODE_OFF;
                m24  = MODE_OFF;
            end
        end
        else
        begin
            fault_q = 1'b0;
        end
    endfunction

    function automatic void drive_920(logic [7:0] cmd, logic [7:0] arg);
        if (m920 != MODE_STANDBY && cmd != CMD_STANDBY && cmd != CMD_OFF)
            park_920();
        if (cmd == CMD_STANDBY)
            park_920();
        else if (cmd == CMD_OFF)
        begin
            pins[P_ON5V] = 1'b0;
            m920 = MODE_OFF;
        end
        else if (cmd == CMD_TX)
        begin
            pins[P_SELPWR_LNA_920] = 1'b0;
            pins[P_SELPWR_AMP_920] = 1'b1;
            pins[P_IN_AMP2_920]    = arg[0];
            pins[P_IN_AMP3_920]    = arg[1];
            m920 = MODE_TX;
        end
    endfunction

    function automatic void drive_24(logic [7:0] cmd, logic [7:0] arg);
        if (m24 != MODE_STANDBY && cmd != CMD_STANDBY && cmd != CMD_OFF)
            park_24();
        if (cmd == CMD_STANDBY)
            park_24();
        else if (cmd == CMD_OFF)
        begin
            pins[P_ON5V] = 1'b0;
            m24 = MODE_OFF;
        end
        else if (cmd == CMD_TX)
        begin
            pins[P_SEL_PWR_LNA_24] = 1'b0;
            pins[P_LNA_IN1_24]     = arg[0];
            pins[P_LNA_IN2_24]     = arg[1];
            pins[P_ON_AMP_24]      = 1'b1;
            m24 = MODE_TX;
        end
    endfunction

    function automatic void bus_command(in_item_t r);
        if (r.byte_count < MIN_CMD_BYTES)
            return;
        lat_status = fault_q;
        lat_len    = '0;
        lat_temp   = '0;
        lat_cur    = '0;
        if (r.amp_select == SEL_GLOBAL)
        begin
            if (r.command == CMD_MONITOR)
            begin
                lat_len  = MONITOR_LEN;
                lat_temp = (temp_c < 0) ? 16'd0 : temp_c[15:0];
                lat_cur  = cur_ma;
            end
            else if (r.command == CMD_RAIL_5V)
                pins[P_ON5V] = (r.argument != 8'd0);
            else if (r.command == CMD_RAIL_50V)
                pins[P_ON50V] = (r.argument != 8'd0);
        end
        else if (r.amp_select == SEL_AMP_920)
        begin
            if (!fault_q)
                drive_920(r.command, r.argument);
        end
        else if (r.amp_select == SEL_AMP_24)
        begin
            if (!fault_q)
                drive_24(r.command, r.argument);
        end
    endfunction

    function automatic out_item_t advance_controller(in_item_t r);
        out_item_t o;
        if (r.req_type == REQ_SAMPLE)
            take_sample(r.temp_raw, r.current_raw);
        else
            bus_command(r);
        o.fault         = fault_q;
        o.resp_status   = lat_status;
        o.resp_data_len = lat_len;
        o.resp_temp     = lat_temp;
        o.resp_current  = lat_cur;
        o.pin_levels    = pins;
        o.mode_920      = m920;
        o.mode_24       = m24;
        return o;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            n_bad++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            temp_lim   = TEMP_LIMIT_RST;
            cur_lim    = CUR_LIMIT_RST;
            fault_q    = 1'b0;
            temp_c     = '0;
            cur_ma     = '0;
            pins       = '0;
            m920       = MODE_OFF;
            m24        = MODE_OFF;
            lat_status = 1'b0;
            lat_len    = '0;
            lat_temp   = '0;
            lat_cur    = '0;
            status_due.delete();
            results_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data.reg_index == CFG_TEMP_LIMIT)
                    temp_lim = cfg_data.wdata;
                else if (cfg_data.reg_index == CFG_CUR_LIMIT)
                    cur_lim = cfg_data.wdata[12:0];
            end

            if (out_valid && out_ready)
            begin
                out_item_t want;
                if (status_due.size() == 0)
                begin
                    n_bad++;
                    $display("%0t ns: result with no request pending, expected none, got 0x%0h",
                             $time, out_data);
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("fault", 32'(want.fault), 32'(out_data.fault));
                    check_field("resp_status", 32'(want.resp_status),
                                32'(out_data.resp_status));
                    check_field("resp_data_len", 32'(want.resp_data_len),
                                32'(out_data.resp_data_len));
                    check_field("resp_temp", 32'(want.resp_temp), 32'(out_data.resp_temp));
                    check_field("resp_current", 32'(want.resp_current),
                                32'(out_data.resp_current));
                    check_field("pin_levels", 32'(want.pin_levels), 32'(out_data.pin_levels));
                    check_field("mode_920", 32'(want.mode_920), 32'(out_data.mode_920));
                    check_field("mode_24", 32'(want.mode_24), 32'(out_data.mode_24));
                end
                results_checked <= results_checked + 1;
            end

            if (in_valid && in_ready)
                status_due.push_back(advance_controller(in_data));
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the RF amplifier controller. All prediction and
// comparison sits in rfamp_state_checker; this module only makes requests,
// programs the limits between phases and paces the result side.
module tb_top;
    import rfamp_pkg::*;

    // bus command request type, the complement of a sensor sample
    localparam logic                 REQ_BUS_CMD = ~REQ_SAMPLE;
    // register index with nothing behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = CFG_IDX_W'(3);

    logic clk;
    logic rst_n;

    rfamp_chan_if #(.T(in_item_t))  req_ch ();
    rfamp_chan_if #(.T(out_item_t)) rsp_ch ();
    rfamp_chan_if #(.T(cfg_req_t))  cfg_ch ();

    int failures;
    int results_checked;
    int n_sent;
    bit sender_quiet;

    rf_amp_mode_and_fault_controller_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (req_ch),
        .out   (rsp_ch),
        .cfg   (cfg_ch)
    );

    rfamp_state_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (req_ch.valid),
        .in_ready        (req_ch.ready),
        .in_data         (req_ch.data),
        .out_valid       (rsp_ch.valid),
        .out_ready       (rsp_ch.ready),
        .out_data        (rsp_ch.data),
        .cfg_valid       (cfg_ch.valid),
        .cfg_ready       (cfg_ch.ready),
        .cfg_data        (cfg_ch.data),
        .failures        (failures),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every request waiting out
    // both the longest sender gap and the longest result stall, plus hold-offs).
    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request builders. Fields a request type ignores are still random so
    // that every bit of every field gets toggled.
    // ------------------------------------------------------------------
    function automatic in_item_t bus_cmd(logic [5:0] bytes, logic [7:0] cmd,
                                         logic [7:0] sel, logic [7:0] arg);
        in_item_t r;
        r.req_type    = REQ_BUS_CMD;
        r.temp_raw    = 12'($urandom);
        r.current_raw = 12'($urandom);
        r.byte_count  = bytes;
        r.command     = cmd;
        r.amp_select  = sel;
        r.argument    = arg;
        return r;
    endfunction

    function automatic in_item_t sensor(logic [11:0] t_raw, logic [11:0] c_raw);
        in_item_t r;
        r             = bus_cmd(6'($urandom_range(0, 32)), 8'($urandom), 8'($urandom),
                                8'($urandom));
        r.req_type    = REQ_SAMPLE;
        r.temp_raw    = t_raw;
        r.current_raw = c_raw;
        return r;
    endfunction

    // Mostly well-formed traffic: cool samples within limits so that commands
    // get past the fault gate, known codes and targets, a little noise.
    function automatic in_item_t random_request();
        logic [11:0] t_raw;
        logic [11:0] c_raw;
        logic [5:0]  bytes;
        logic [7:0]  cmd;
        logic [7:0]  sel;

        t_raw = ($urandom_range(0, 9) < 6) ? 12'($urandom_range(1500, 4095))
                                           : 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 9))
            0:       c_raw = '0;
            8, 9:    c_raw = 12'($urandom_range(0, 4095));
            default: c_raw = 12'($urandom_range(0, 3000));
        endcase
        if ($urandom_range(0, 3) == 0)
            return sensor(t_raw, c_raw);

        bytes = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 3))
                                            : 6'($urandom_range(4, 32));
        case ($urandom_range(0, 13))
            0:       cmd = CMD_MONITOR;
            1:       cmd = CMD_RAIL_5V;
            2:       cmd = CMD_RAIL_50V;
            3, 4, 5: cmd = CMD_STANDBY;
            6, 7:    cmd = CMD_OFF;
            8, 9,
            10, 11:  cmd = CMD_TX;
            default: cmd = 8'($urandom);
        endcase
        case ($urandom_range(0, 12))
            0, 1, 2: sel = SEL_GLOBAL;
            3, 4, 5,
            6, 7:    sel = SEL_AMP_920;
            8, 9,
            10, 11:  sel = SEL_AMP_24;
            default: sel = 8'($urandom);
        endcase
        return bus_cmd(bytes, cmd, sel, 8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Request side. A random gap before each request, with stretches
    // of back-to-back traffic chosen every 128 requests.
    // ------------------------------------------------------------------
    task automatic send_request(in_item_t r);
        int gap;
        if (n_sent % 128 == 0)
            sender_quiet = ($urandom_range(0, 3) == 0);
        gap = sender_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic pump_random(int count);
        repeat (count)
            send_request(random_request());
        req_ch.valid <= 1'b0;
    endtask

    // every request gives exactly one result, so idle means all results in
    task automatic wait_drained();
        while (results_checked != n_sent)
            @(posedge clk);
    endtask

    // Limits are only reprogrammed with the controller idle. Optionally pokes
    // an unused index to show it changes nothing.
    task automatic program_limits(int temp_lim, int cur_lim, bit poke_spare);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{reg_index: CFG_TEMP_LIMIT, wdata: 17'(temp_lim)};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.data  <= '{reg_index: CFG_CUR_LIMIT, wdata: 17'(cur_lim)};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (poke_spare)
        begin
            cfg_ch.data <= '{reg_index: CFG_SPARE, wdata: 17'($urandom)};
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side. A random stall before each result, quiet stretches,
    // and two long hold-offs so the pipeline fills and back-pressures the
    // request channel while requests keep coming.
    // ------------------------------------------------------------------
    initial
    begin : result_pacer
        int  taken;
        int  stall;
        bit  quiet;

        taken = 0;
        quiet = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 128 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (taken == 300 || taken == 1200)
                stall = 150;
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        n_sent       = 0;
        sender_quiet = 1'b0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at reset limits (9000 centi-degrees, 4500 mA).
        // Short commands: nothing moves, response stays at reset
        send_request(bus_cmd(6'd0, CMD_MONITOR, SEL_GLOBAL, 8'h00));
        send_request(bus_cmd(6'd3, CMD_RAIL_5V, SEL_GLOBAL, 8'hFF));
        // monitor before any sample reports zeroes with length 4
        send_request(bus_cmd(6'd4, CMD_MONITOR, SEL_GLOBAL, 8'h00));
        send_request(bus_cmd(6'd4, CMD_RAIL_5V, SEL_GLOBAL, 8'h01));
        send_request(bus_cmd(6'd5, CMD_RAIL_50V, SEL_GLOBAL, 8'h80));
        // 920 chain: standby, transmit, transmit again from transmit
        send_request(bus_cmd(6'd6, CMD_STANDBY, SEL_AMP_920, 8'h00));
        send_request(bus_cmd(6'd7, CMD_TX, SEL_AMP_920, 8'h03));
        send_request(bus_cmd(6'd8, CMD_TX, SEL_AMP_920, 8'h02));
        // 24 chain: transmit straight from off goes through standby first
        send_request(bus_cmd(6'd9, CMD_TX, SEL_AMP_24, 8'h01));
        send_request(bus_cmd(6'd10, CMD_STANDBY, SEL_AMP_24, 8'h00));
        send_request(bus_cmd(6'd11, CMD_OFF, SEL_AMP_24, 8'h00));
        send_request(bus_cmd(6'd12, CMD_OFF, SEL_AMP_920, 8'h00));
        // unknown code to a chain that is off still parks it in standby
        send_request(bus_cmd(6'd13, 8'h55, SEL_AMP_920, 8'hAA));
        // unknown target only latches the response
        send_request(bus_cmd(6'd14, CMD_STANDBY, 8'h07, 8'h00));
        // hottest reading trips the fault, second one must not repeat shutdown
        send_request(sensor(12'd0, 12'd0));
        send_request(sensor(12'd0, 12'hFFF));
        // amplifier request during fault is dropped but still latched
        send_request(bus_cmd(6'd15, CMD_TX, SEL_AMP_920, 8'h03));
        send_request(bus_cmd(6'd16, CMD_MONITOR, SEL_GLOBAL, 8'h00));
        // coldest reading clears the fault; monitor saturates the negative temp
        send_request(sensor(12'hFFF, 12'd0));
        send_request(bus_cmd(6'd31, CMD_MONITOR, SEL_GLOBAL, 8'h00));
        // over-current trips, a quiet reading clears without restoring pins
        send_request(sensor(12'd2000, 12'hFFF));
        send_request(sensor(12'd2000, 12'd0));
        send_request(bus_cmd(6'd32, CMD_RAIL_5V, SEL_GLOBAL, 8'h00));
        send_request(bus_cmd(6'd32, 8'hFF, SEL_GLOBAL, 8'hFF));
        send_request(sensor(12'hFFF, 12'hFFF));

        pump_random(350);

        // lowest temperature limit: every sample is over temperature
        program_limits(-41000, 5000, 1'b0);
        pump_random(150);

        // zero current limit, temperature never trips
        program_limits(35800, 0, 1'b0);
        pump_random(150);

        // widest limits: no faults, chains free to move
        program_limits(35800, 5000, 1'b0);
        pump_random(350);

        program_limits($urandom_range(0, 76800) - 41000, $urandom_range(0, 5000), 1'b1);
        pump_random(400);

        program_limits(9000, 4500, 1'b0);
        pump_random(450);

        // drain, then keep watching the result side to catch any stray result
        wait_drained();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rfamp_pkg.sv
rtl/rfamp_chan_if.sv
rtl/rfamp_conv.sv
rtl/rfamp_core.sv
rtl/rf_amp_mode_and_fault_controller_top.sv
tb/rfamp_checker.sv
tb/tb_top.sv
